// ===== sv/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// sle_pkg
// Shared beat types and character codes for the serial line editor.
// ----------------------------------------------------------------------------
package sle_pkg;

    // Input beat: a received byte or a release of the completed line
    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } sle_item_t;

    // Output beat: one character of a completed line, or a marker for an empty line
    typedef struct packed {
        logic [7:0] line_byte;
        logic       byte_valid;
        logic       last;
        logic       overflow;
    } sle_result_t;

    // Operation codes
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Character codes
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

endpackage

// ===== sv/sle_line_ram.sv =====
// ----------------------------------------------------------------------------
// sle_line_ram
// Line store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sle_line_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write one character
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, hold data between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/serial_line_editor.sv =====
// A completing byte passes a memory read state (ST_READ) and an output load
// state (ST_SEND) before its first result beat; an empty line goes straight to
// one output load (ST_EMPTY). Each further character takes one read and one
// load; result_stall can hold a load. Throughput: other items are taken one
// per cycle; input stalls while a line is emitted. Reset clears the position,
// the pending and dropped flags and the output register; the store is not cleared.
// ----------------------------------------------------------------------------
// serial_line_editor
// Builds a command line from received bytes and emits it on completion.
// ----------------------------------------------------------------------------
module serial_line_editor
    import sle_pkg::*;
#(
    parameter int LINE_CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  sle_item_t   item,
    output logic        result_valid,
    input  logic        result_stall,
    output sle_result_t result
);

    localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
    localparam int PW = $clog2(LINE_CAPACITY + 1);
    localparam logic [PW-1:0] CAP = PW'(LINE_CAPACITY);
    localparam logic [PW-1:0] ONE = PW'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEND,
        ST_EMPTY
    } state_t;

    state_t      state_reg, state_next;
    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] idx_reg, idx_next;
    logic        pending_reg, pending_next;
    logic        dropped_reg, dropped_next;
    logic        result_valid_reg, result_valid_next;
    sle_result_t result_reg, result_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [7:0]    rd_data;
    logic          accept;
    logic          out_free;
    logic          at_last;

    sle_line_ram #(
        .DEPTH (LINE_CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign accept   = item_valid && (state_reg == ST_IDLE);
    assign out_free = !result_valid_reg || !result_stall;
    assign at_last  = (idx_reg == (wp_reg - ONE));

    // Edit the line, walk the store on completion
    always_comb
    begin
        state_next        = state_reg;
        wp_next           = wp_reg;
        idx_next          = idx_reg;
        pending_next      = pending_reg;
        dropped_next      = dropped_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        wr_en             = 1'b0;
        wr_addr           = wp_reg[AW-1:0];
        wr_data           = item.rx_byte;
        rd_en             = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.operation == OP_RELEASE)
                    begin
                        wp_next      = '0;
                        pending_next = 1'b0;
                        dropped_next = 1'b0;
                    end
                    else if (!pending_reg)
                    begin
                        if (item.rx_byte inside {CH_CR, CH_BSLASH, CH_SLASH})
                        begin
                            idx_next   = '0;
                            state_next = (wp_reg == '0) ? ST_EMPTY : ST_READ;
                        end
                        else
                        begin
                            case (item.rx_byte)
                                CH_BS:
                                begin
                                    if (wp_reg != '0)
                                    begin
                                        wp_next = wp_reg - ONE;
                                    end
                                end
                                CH_ESC:
                                begin
                                    wp_next      = '0;
                                    dropped_next = 1'b0;
                                end
                                CH_DOLLAR:
                                begin
                                    wr_en        = 1'b1;
                                    wr_addr      = '0;
                                    wp_next      = ONE;
                                    dropped_next = 1'b0;
                                end
                                default:
                                begin
                                    if (wp_reg < CAP)
                                    begin
                                        wr_en   = 1'b1;
                                        wp_next = wp_reg + ONE;
                                    end
                                    else
                                    begin
                                        dropped_next = 1'b1;
                                    end
                                end
                            endcase
                        end
                    end
                end
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_free)
                begin
                    result_valid_next      = 1'b1;
                    result_next.line_byte  = rd_data;
                    result_next.byte_valid = 1'b1;
                    result_next.last       = at_last;
                    result_next.overflow   = dropped_reg;
                    if (at_last)
                    begin
                        wp_next      = '0;
                        pending_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ONE;
                        state_next = ST_READ;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    result_valid_next      = 1'b1;
                    result_next.line_byte  = '0;
                    result_next.byte_valid = 1'b0;
                    result_next.last       = 1'b1;
                    result_next.overflow   = dropped_reg;
                    pending_next           = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            wp_reg           <= '0;
            idx_reg          <= '0;
            pending_reg      <= 1'b0;
            dropped_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            wp_reg           <= wp_next;
            idx_reg          <= idx_next;
            pending_reg      <= pending_next;
            dropped_reg      <= dropped_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
